@@ hw/rtl/ps2mc_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mc_pkg
// Shared types and constants for the PS/2 mouse packet cursor.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 2'd2;

    localparam int RESET_X    = 40;
    localparam int RESET_Y    = 12;
    localparam int RESET_XLIM = 79;
    localparam int RESET_YLIM = 24;

    localparam int SYNC_BIT = 3;

    typedef enum logic [2:0] {
        CNT_HEAD = 3'b001,
        CNT_DX   = 3'b010,
        CNT_DY   = 3'b100
    } t_pkt_phase;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] x_limit;
        logic [CFG_W-1:0] y_limit;
    } t_cfg;

endpackage

@@ hw/rtl/ps2_mouse_packet_cursor.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// PS/2 mouse packet decoder driving a clamped character-cell cursor.
// ----------------------------------------------------------------------------
// Takes one mouse byte per cycle. A byte enters an input register and is
// decoded from there; a new byte may enter as the held one is taken. A
// result word is loaded into the result register when the decoder takes
// the third byte of a packet, so that byte passes the input register and
// then the result register. The input side stalls only while a finished
// result waits and the output side is stalled. Packets are
// aligned on a first byte with bit 3 set; a cleared enable discards bytes and
// restarts alignment. Reset places the cursor at column 40, row 12.
module ps2_mouse_packet_cursor #(
    parameter int COORD_BITS = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ps2mc_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [COORD_BITS-1:0]            o_x_pos,
    output logic [COORD_BITS-1:0]            o_y_pos,
    output logic                             o_left_button,
    output logic                             o_right_button,
    output logic                             o_middle_button
);

    ps2mc_pkg::t_cfg cfg;
    logic            take;
    logic            s1_valid;
    logic [7:0]      s1_byte;

    ps2mc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ps2mc_in_reg u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_take     (take),
        .o_valid    (s1_valid),
        .o_byte     (s1_byte)
    );

    ps2mc_decode #(
        .COORD_BITS (COORD_BITS)
    ) u_dec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (s1_valid),
        .i_byte          (s1_byte),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_x_pos         (o_x_pos),
        .o_y_pos         (o_y_pos),
        .o_left_button   (o_left_button),
        .o_right_button  (o_right_button),
        .o_middle_button (o_middle_button)
    );

endmodule

@@ hw/rtl/ps2mc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ps2mc_cfg_regs
// Configuration registers: enable and the two cursor limits.
// ----------------------------------------------------------------------------
module ps2mc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ps2mc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ps2mc_pkg::CFG_W-1:0]      i_cfg_data,
    output ps2mc_pkg::t_cfg                  o_cfg
);

    ps2mc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable  <= 1'b1;
            r_cfg.x_limit <= ps2mc_pkg::CFG_W'(ps2mc_pkg::RESET_XLIM);
            r_cfg.y_limit <= ps2mc_pkg::CFG_W'(ps2mc_pkg::RESET_YLIM);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ps2mc_pkg::CFG_ENABLE:  r_cfg.enable  <= i_cfg_data[0];
                ps2mc_pkg::CFG_X_LIMIT: r_cfg.x_limit <= i_cfg_data;
                ps2mc_pkg::CFG_Y_LIMIT: r_cfg.y_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/ps2mc_in_reg.sv @@
// ----------------------------------------------------------------------------
// ps2mc_in_reg
// Input register: holds one received byte until the decoder takes it.
// ----------------------------------------------------------------------------
module ps2mc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       accept;

    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ hw/rtl/ps2mc_decode.sv @@
// ----------------------------------------------------------------------------
// ps2mc_decode
// Packet assembly, clamped cursor update and result register.
// ----------------------------------------------------------------------------
module ps2mc_decode #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ps2mc_pkg::t_cfg       i_cfg,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    output logic                  o_take,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_x_pos,
    output logic [COORD_BITS-1:0] o_y_pos,
    output logic                  o_left_button,
    output logic                  o_right_button,
    output logic                  o_middle_button
);

    localparam int CMAX = (1 << COORD_BITS) - 1;
    localparam int SW   = ((COORD_BITS > ps2mc_pkg::CFG_W) ? COORD_BITS
                                                           : ps2mc_pkg::CFG_W) + 2;
    localparam int X0   = (ps2mc_pkg::RESET_X > CMAX) ? CMAX : ps2mc_pkg::RESET_X;
    localparam int Y0   = (ps2mc_pkg::RESET_Y > CMAX) ? CMAX : ps2mc_pkg::RESET_Y;
    localparam logic [SW-1:0] CMAX_W = SW'(CMAX);

    ps2mc_pkg::t_pkt_phase r_count;
    ps2mc_pkg::t_pkt_phase n_count;
    logic [7:0]            r_held0;
    logic [7:0]            n_held0;
    logic [7:0]            r_held1;
    logic [7:0]            n_held1;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] n_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [COORD_BITS-1:0] n_cy;
    logic                  fire;
    logic                  out_free;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_x_pos;
    logic [COORD_BITS-1:0] r_y_pos;
    logic [2:0]            r_buttons;

    logic [SW-1:0]        x_lim;
    logic [SW-1:0]        y_lim;
    logic signed [SW-1:0] x_sum;
    logic signed [SW-1:0] y_sum;
    logic [COORD_BITS-1:0] x_new;
    logic [COORD_BITS-1:0] y_new;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_take   = i_valid && out_free;

    // limits saturate at the coordinate range
    always_comb begin
        x_lim = SW'(i_cfg.x_limit);
        y_lim = SW'(i_cfg.y_limit);
        if (x_lim > CMAX_W) begin
            x_lim = CMAX_W;
        end
        if (y_lim > CMAX_W) begin
            y_lim = CMAX_W;
        end
    end

    // x adds its motion, y subtracts it
    assign x_sum = $signed(SW'(r_cx)) + SW'($signed(r_held1));
    assign y_sum = $signed(SW'(r_cy)) - SW'($signed(i_byte));

    always_comb begin
        if (x_sum < 0) begin
            x_new = '0;
        end else if (x_sum > $signed(x_lim)) begin
            x_new = x_lim[COORD_BITS-1:0];
        end else begin
            x_new = x_sum[COORD_BITS-1:0];
        end
        if (y_sum < 0) begin
            y_new = '0;
        end else if (y_sum > $signed(y_lim)) begin
            y_new = y_lim[COORD_BITS-1:0];
        end else begin
            y_new = y_sum[COORD_BITS-1:0];
        end
    end

    always_comb begin
        n_count = r_count;
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_cx    = r_cx;
        n_cy    = r_cy;
        fire    = 1'b0;
        if (!i_cfg.enable) begin
            n_count = ps2mc_pkg::CNT_HEAD;
        end else begin
            unique case (r_count)
                ps2mc_pkg::CNT_HEAD: begin
                    if (i_byte[ps2mc_pkg::SYNC_BIT]) begin
                        n_held0 = i_byte;
                        n_count = ps2mc_pkg::CNT_DX;
                    end
                end
                ps2mc_pkg::CNT_DX: begin
                    n_held1 = i_byte;
                    n_count = ps2mc_pkg::CNT_DY;
                end
                ps2mc_pkg::CNT_DY: begin
                    n_count = ps2mc_pkg::CNT_HEAD;
                    n_cx    = x_new;
                    n_cy    = y_new;
                    fire    = 1'b1;
                end
                default: begin
                    n_count = ps2mc_pkg::CNT_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= ps2mc_pkg::CNT_HEAD;
            r_cx        <= X0[COORD_BITS-1:0];
            r_cy        <= Y0[COORD_BITS-1:0];
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_count <= n_count;
                r_cx    <= n_cx;
                r_cy    <= n_cy;
            end
            if (out_free) begin
                r_out_valid <= o_take && fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
        if (o_take && fire) begin
            r_x_pos   <= n_cx;
            r_y_pos   <= n_cy;
            r_buttons <= r_held0[2:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_x_pos         = r_x_pos;
    assign o_y_pos         = r_y_pos;
    assign o_left_button   = r_buttons[0];
    assign o_right_button  = r_buttons[1];
    assign o_middle_button = r_buttons[2];

endmodule

@@ hw/rtl/ps2mc_checker.sv @@
// ----------------------------------------------------------------------------
// ps2mc_checker
// Port-level checks for the PS/2 mouse packet cursor.
// ----------------------------------------------------------------------------
module ps2mc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // a fresh result follows a byte accepted at the input, through the input and result registers
    a_rise_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a preceding byte");

endmodule

bind ps2_mouse_packet_cursor ps2mc_checker u_ps2mc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
